>>> rtl/svpm_pkg.sv
// Shared constants, types and switching tables of the space vector PWM modulator.
package svpm_pkg;

  localparam int VOLT_WIDTH_DEF = 16;
  localparam int DUTY_FRAC_DEF  = 16;
  localparam int PERIOD_W       = 16;
  localparam int SECTOR_W       = 3;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DC_LINK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd1;

  localparam int unsigned DC_LINK_RESET = 5000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;

  localparam logic [SECTOR_W-1:0] SECTOR_0   = 3'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_1   = 3'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_2   = 3'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_3   = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_4   = 3'd4;
  localparam logic [SECTOR_W-1:0] SECTOR_5   = 3'd5;

  // sqrt(3) scaled by 2^30, rounded.
  localparam longint unsigned SQRT3_Q30 = 64'd1859775393;

  // Status of the iterative divider as seen by its sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Switch states of the left active vector of each sector; bit 0 is phase A.
  function automatic logic [2:0] sw_left(input logic [SECTOR_W-1:0] s);
    logic [2:0] v;
    case (s)
      SECTOR_0: v = 3'b011;
      SECTOR_1: v = 3'b010;
      SECTOR_2: v = 3'b110;
      SECTOR_3: v = 3'b100;
      SECTOR_4: v = 3'b101;
      SECTOR_5: v = 3'b001;
      default:  v = 3'b000;
    endcase
    return v;
  endfunction

  // Switch states of the right active vector of each sector; bit 0 is phase A.
  function automatic logic [2:0] sw_right(input logic [SECTOR_W-1:0] s);
    logic [2:0] v;
    case (s)
      SECTOR_0: v = 3'b001;
      SECTOR_1: v = 3'b011;
      SECTOR_2: v = 3'b010;
      SECTOR_3: v = 3'b110;
      SECTOR_4: v = 3'b100;
      SECTOR_5: v = 3'b101;
      default:  v = 3'b000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/svpm_if.sv
// Valid/ready channel interfaces of the modulator: reference in, result out, register writes.
interface svpm_in_if #(parameter int VOLT_WIDTH = svpm_pkg::VOLT_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] v_alpha;
  logic signed [VOLT_WIDTH-1:0] v_beta;
  modport source (output valid, v_alpha, v_beta, input ready);
  modport sink   (input valid, v_alpha, v_beta, output ready);
endinterface

interface svpm_out_if #(parameter int DUTY_FRAC_BITS = svpm_pkg::DUTY_FRAC_DEF);
  logic                         valid;
  logic                         ready;
  logic                         gate_a;
  logic                         gate_b;
  logic                         gate_c;
  logic [DUTY_FRAC_BITS:0]      duty_a_out;
  logic [DUTY_FRAC_BITS:0]      duty_b_out;
  logic [DUTY_FRAC_BITS:0]      duty_c_out;
  logic [svpm_pkg::SECTOR_W-1:0] sector_out;
  logic                         duty_updated;
  logic [svpm_pkg::PERIOD_W-1:0] carrier_phase;
  modport source (output valid, gate_a, gate_b, gate_c, duty_a_out, duty_b_out, duty_c_out,
                  sector_out, duty_updated, carrier_phase, input ready);
  modport sink   (input valid, gate_a, gate_b, gate_c, duty_a_out, duty_b_out, duty_c_out,
                  sector_out, duty_updated, carrier_phase, output ready);
endinterface

interface svpm_cfg_if #(parameter int DATA_W = svpm_pkg::PERIOD_W);
  logic                           valid;
  logic                           ready;
  logic [svpm_pkg::CFG_IDX_W-1:0] addr;
  logic [DATA_W-1:0]              data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/svpm_mul.sv
// Shared unsigned multiplier with a registered product.
module svpm_mul #(
  parameter int OPW = 32
) (
  input  logic             clk,
  input  logic [OPW-1:0]   op_a,
  input  logic [OPW-1:0]   op_b,
  output logic [2*OPW-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> rtl/svpm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module svpm_div #(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output svpm_pkg::div_stat_t   stat,
  output logic [DIVIDEND_W-1:0] quotient
);
  import svpm_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  q_bit;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= (divisor == '0) ? DIVISOR_W'(1) : divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
`endif

endmodule

>>> rtl/space_vector_pwm_modulator_top.sv
// Top level of the space vector PWM modulator: tick sequencer, sector and dwell solve, gates.
//
//  channel  | role   | transfer carries
//  ---------+--------+---------------------------------------------------------------
//  in_ch    | sink   | one carrier tick: v_alpha, v_beta
//  out_ch   | source | gates, latched duties, sector, update flag, carrier phase
//  cfg_ch   | sink   | register write: addr 0 dc_link_voltage, addr 1 period_ticks
//
// A plain tick raises the result valid after three passes through the shared multiplier for the
// gate compares. A tick at phase 1 also solves the dwell times first, with the one-bit-per-cycle
// divider run twice. One tick is in work at a time; the next is taken while a result still waits
// in the output register. Reset (rst_n low, synchronous) clears the phase, duties and sector and
// loads the register defaults. Configuration writes are always taken.
module space_vector_pwm_modulator_top #(
  parameter int VOLT_WIDTH     = svpm_pkg::VOLT_WIDTH_DEF,
  parameter int DUTY_FRAC_BITS = svpm_pkg::DUTY_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  svpm_in_if.sink    in_ch,
  svpm_out_if.source out_ch,
  svpm_cfg_if.sink   cfg_ch
);
  import svpm_pkg::*;

  localparam int VW     = VOLT_WIDTH;
  localparam int F      = DUTY_FRAC_BITS;
  localparam int DUTYW  = F + 1;
  localparam int MW0    = (VW > F + 3) ? VW : F + 3;
  localparam int MW     = (MW0 > PERIOD_W) ? MW0 : PERIOD_W;
  localparam int NW     = VW + F + 6;
  localparam int DW     = NW - 4;
  localparam int VWD    = DW + 3;
  localparam int CW     = (2 * MW > F + PERIOD_W + 1) ? 2 * MW : F + PERIOD_W + 1;
  localparam int PW     = (2 * MW > NW) ? 2 * MW : NW;
  localparam int SQW    = 2 * MW + 2;
  localparam logic [MW-1:0]    SQ_K  = MW'(SQRT3_Q30 >> (28 - F));
  localparam logic [DUTYW-1:0] ONE_D = {1'b1, {F{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_A, S_SQ_B, S_SQ_SB, S_SECT, S_NUM, S_ABS, S_DIV, S_DUTY,
    S_GATE_A, S_GATE_B, S_GATE_C, S_GATE_D, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0]       dc_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] phase_r;
  logic [DUTYW-1:0]    duty_a_r, duty_b_r, duty_c_r;
  logic [SECTOR_W-1:0] sector_r;
  logic                out_valid_r;

  logic signed [VW-1:0] alpha_r, beta_r;
  logic                 upd_r;
  logic                 k_r;
  logic [2*MW-1:0]      aa2_r, bb2_r;
  logic [SQW-1:0]       a3_r;
  logic signed [NW-1:0] pv_r, qv_r, n_r;
  logic                 neg_r;
  logic signed [DW:0]   d0_r, d1_r;
  logic [PERIOD_W:0]    tri_r;
  logic [2:0]           gate_r;

  logic                 o_gate_a_r, o_gate_b_r, o_gate_c_r, o_upd_r;
  logic [DUTYW-1:0]     o_duty_a_r, o_duty_b_r, o_duty_c_r;
  logic [SECTOR_W-1:0]  o_sector_r;
  logic [PERIOD_W-1:0]  o_phase_r;

  logic                 in_fire, out_fire, cfg_fire;
  logic [PERIOD_W-1:0]  n_eff;
  logic [PERIOD_W:0]    phase_inc;
  logic [PERIOD_W-1:0]  phase_new;
  logic [VW-1:0]        a_mag, b_mag;
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      mul_p;
  logic [PW-1:0]        prod_ext;
  logic signed [NW-1:0] p_mag, ax, q_val;
  logic [SECTOR_W-1:0]  sect_new;
  logic                 sq_le, sq_ge;
  logic signed [NW-1:0] n_sel, n_abs;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [DW-1:0]        div_q;
  logic signed [DW:0]   d_signed;
  logic [DUTYW-1:0]     duty_nxt [3];
  logic                 gate_ge;
  logic [PERIOD_W:0]    two_ph, n17;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Carrier phase advance; a lowered period makes an out-of-range phase wrap to zero.
  always_comb begin
    n_eff     = (period_r < PERIOD_MIN) ? PERIOD_MIN : period_r;
    phase_inc = {1'b0, phase_r} + 1'b1;
    phase_new = (phase_inc >= {1'b0, n_eff}) ? '0 : phase_inc[PERIOD_W-1:0];
  end

  assign a_mag = alpha_r[VW-1] ? VW'(-alpha_r) : VW'(alpha_r);
  assign b_mag = beta_r[VW-1]  ? VW'(-beta_r)  : VW'(beta_r);

  // Operand selection for the shared multiplier; the registered product is used in the next state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_A: begin
        mul_a = MW'(a_mag);
        mul_b = MW'(a_mag);
      end
      S_SQ_B: begin
        mul_a = MW'(b_mag);
        mul_b = MW'(b_mag);
      end
      S_SQ_SB: begin
        mul_a = SQ_K;
        mul_b = MW'(b_mag);
      end
      S_GATE_A: begin
        mul_a = MW'(duty_a_r);
        mul_b = MW'(n_eff);
      end
      S_GATE_B: begin
        mul_a = MW'(duty_b_r);
        mul_b = MW'(n_eff);
      end
      S_GATE_C: begin
        mul_a = MW'(duty_c_r);
        mul_b = MW'(n_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  svpm_mul #(.OPW(MW)) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // Sector search; the boundaries are tested in sector order so the first match wins.
  always_comb begin
    prod_ext = PW'(mul_p);
    p_mag    = signed'(prod_ext[NW-1:0]);
    ax       = NW'(alpha_r);
    q_val    = ((ax <<< 1) + ax) <<< (F + 2);
    sq_le    = (SQW'(bb2_r) <= a3_r);
    sq_ge    = (SQW'(bb2_r) >= a3_r);
    if (!beta_r[VW-1]) begin
      if (!alpha_r[VW-1] && sq_le) begin
        sect_new = SECTOR_0;
      end else if (sq_ge) begin
        sect_new = SECTOR_1;
      end else begin
        sect_new = SECTOR_2;
      end
    end else begin
      if (alpha_r[VW-1] && sq_le) begin
        sect_new = SECTOR_3;
      end else if (sq_ge) begin
        sect_new = SECTOR_4;
      end else begin
        sect_new = SECTOR_5;
      end
    end
  end

  // Dwell numerators with the sector determinant (always -2) folded into the signs.
  always_comb begin
    n_sel = '0;
    if (!k_r) begin
      case (sector_r)
        SECTOR_0: n_sel = pv_r <<< 1;
        SECTOR_1: n_sel = pv_r - qv_r;
        SECTOR_2: n_sel = -pv_r - qv_r;
        SECTOR_3: n_sel = -(pv_r <<< 1);
        SECTOR_4: n_sel = qv_r - pv_r;
        SECTOR_5: n_sel = pv_r + qv_r;
        default:  n_sel = '0;
      endcase
    end else begin
      case (sector_r)
        SECTOR_0: n_sel = qv_r - pv_r;
        SECTOR_1: n_sel = qv_r + pv_r;
        SECTOR_2: n_sel = pv_r <<< 1;
        SECTOR_3: n_sel = pv_r - qv_r;
        SECTOR_4: n_sel = -qv_r - pv_r;
        SECTOR_5: n_sel = -(pv_r <<< 1);
        default:  n_sel = '0;
      endcase
    end
  end

  assign n_abs     = n_r[NW-1] ? -n_r : n_r;
  assign div_start = (state_r == S_ABS);

  // The denominator 8*Vdc is split into a shift by three and a divide by Vdc.
  svpm_div #(.DIVIDEND_W(DW), .DIVISOR_W(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_abs[NW-2:3]),
    .divisor  (dc_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign d_signed = neg_r ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});

  // Phase duties: one half of (1 +/- d0 +/- d1), clamped to the range 0..1.
  always_comb begin
    logic [2:0]            sl, sr;
    logic signed [VWD-1:0] v, d0e, d1e, half;
    sl  = sw_left(sector_r);
    sr  = sw_right(sector_r);
    d0e = VWD'(d0_r);
    d1e = VWD'(d1_r);
    for (int ph = 0; ph < 3; ph++) begin
      v    = signed'(VWD'(ONE_D)) + (sl[ph] ? d0e : -d0e) + (sr[ph] ? d1e : -d1e);
      half = v >>> 1;
      if (v <= 0) begin
        duty_nxt[ph] = '0;
      end else if (half > signed'(VWD'(ONE_D))) begin
        duty_nxt[ph] = ONE_D;
      end else begin
        duty_nxt[ph] = half[DUTYW-1:0];
      end
    end
  end

  // Triangle carrier: the gate is on while duty*N is at least |2*phase - N| scaled by 2^F.
  always_comb begin
    two_ph  = {phase_r, 1'b0};
    n17     = {1'b0, n_eff};
    gate_ge = (CW'(mul_p) >= (CW'(tri_r) << F));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = (phase_new == PERIOD_W'(1)) ? S_SQ_A : S_GATE_A;
      S_SQ_A:   state_nxt = S_SQ_B;
      S_SQ_B:   state_nxt = S_SQ_SB;
      S_SQ_SB:  state_nxt = S_SECT;
      S_SECT:   state_nxt = S_NUM;
      S_NUM:    state_nxt = S_ABS;
      S_ABS:    state_nxt = S_DIV;
      S_DIV:    if (div_stat.done) state_nxt = k_r ? S_DUTY : S_NUM;
      S_DUTY:   state_nxt = S_GATE_A;
      S_GATE_A: state_nxt = S_GATE_B;
      S_GATE_B: state_nxt = S_GATE_C;
      S_GATE_C: state_nxt = S_GATE_D;
      S_GATE_D: state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dc_r        <= VW'(DC_LINK_RESET);
      period_r    <= PERIOD_RESET;
      phase_r     <= '0;
      duty_a_r    <= '0;
      duty_b_r    <= '0;
      duty_c_r    <= '0;
      sector_r    <= SECTOR_0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_ch.addr)
          REG_DC_LINK: dc_r     <= cfg_ch.data[VW-1:0];
          REG_PERIOD:  period_r <= cfg_ch.data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r <= phase_new;
      end
      if (state_r == S_SECT) begin
        sector_r <= sect_new;
      end
      if (state_r == S_DUTY) begin
        duty_a_r <= duty_nxt[0];
        duty_b_r <= duty_nxt[1];
        duty_c_r <= duty_nxt[2];
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      alpha_r <= in_ch.v_alpha;
      beta_r  <= in_ch.v_beta;
      upd_r   <= (phase_new == PERIOD_W'(1));
      k_r     <= 1'b0;
    end
    if (state_r == S_SQ_B) begin
      aa2_r <= mul_p;
    end
    if (state_r == S_SQ_SB) begin
      bb2_r <= mul_p;
      a3_r  <= SQW'(aa2_r) + (SQW'(aa2_r) << 1);
    end
    if (state_r == S_SECT) begin
      pv_r <= beta_r[VW-1] ? -p_mag : p_mag;
      qv_r <= q_val;
    end
    if (state_r == S_NUM) begin
      n_r <= n_sel;
    end
    if (state_r == S_ABS) begin
      neg_r <= n_r[NW-1];
    end
    if (state_r == S_DIV && div_stat.done) begin
      if (!k_r) begin
        d0_r <= d_signed;
        k_r  <= 1'b1;
      end else begin
        d1_r <= d_signed;
      end
    end
    if (state_r == S_GATE_A) begin
      tri_r <= (two_ph >= n17) ? (two_ph - n17) : (n17 - two_ph);
    end
    if (state_r == S_GATE_B) gate_r[0] <= gate_ge;
    if (state_r == S_GATE_C) gate_r[1] <= gate_ge;
    if (state_r == S_GATE_D) gate_r[2] <= gate_ge;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      o_gate_a_r <= gate_r[0];
      o_gate_b_r <= gate_r[1];
      o_gate_c_r <= gate_r[2];
      o_duty_a_r <= duty_a_r;
      o_duty_b_r <= duty_b_r;
      o_duty_c_r <= duty_c_r;
      o_sector_r <= sector_r;
      o_upd_r    <= upd_r;
      o_phase_r  <= phase_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.gate_a        = o_gate_a_r;
  assign out_ch.gate_b        = o_gate_b_r;
  assign out_ch.gate_c        = o_gate_c_r;
  assign out_ch.duty_a_out    = o_duty_a_r;
  assign out_ch.duty_b_out    = o_duty_b_r;
  assign out_ch.duty_c_out    = o_duty_c_r;
  assign out_ch.sector_out    = o_sector_r;
  assign out_ch.duty_updated  = o_upd_r;
  assign out_ch.carrier_phase = o_phase_r;

`ifndef SYNTHESIS
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE) else $error("accepted tick did not start work");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy) else $error("divider started while busy");
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUTY |=> duty_a_r <= ONE_D && duty_b_r <= ONE_D && duty_c_r <= ONE_D)
    else $error("duty above full scale");
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    sector_r <= SECTOR_5) else $error("sector out of range");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE)) else $error("result raised outside done");
`endif

endmodule
